>>> hw/rtl/lsil_pkg.sv
// Shared types and constants for the line start index lookup unit.
// No dependencies; imported by the top level and the checker.
package lsil_pkg;

    // Default sizing of the line start table and the byte offset.
    localparam int MAX_LINES_DEF   = 4096;
    localparam int OFFSET_BITS_DEF = 32;

    // Field widths of one request and one result.
    localparam int CP_W    = 21;
    localparam int LEN_W   = 3;
    localparam int QOFF_W  = 32;
    localparam int LINE_W  = 13;
    localparam int S_DATA_W = 64;
    localparam int M_DATA_W = 16;

    // Request kinds carried in tuser.
    typedef logic [1:0] t_cmd;
    localparam t_cmd CMD_CLEAR = 2'd0;
    localparam t_cmd CMD_CHAR  = 2'd1;
    localparam t_cmd CMD_QUERY = 2'd2;

    // Break characters.
    localparam logic [CP_W-1:0] CH_LF = CP_W'(10);
    localparam logic [CP_W-1:0] CH_CR = CP_W'(13);

    // Break whose partner is still unknown.
    typedef enum logic [1:0] {
        PEND_NONE = 2'd0,
        PEND_CR   = 2'd1,
        PEND_LF   = 2'd2
    } t_pend;

endpackage

>>> hw/rtl/lsil_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on nothing; used for the line start table.
module lsil_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/line_start_index_lookup_unit.sv
// Line start index lookup unit: builds a table of line start offsets from a
// stream of decoded code points and answers line number queries.
// Depends on lsil_pkg and lsil_ram.
//
// Usage
//   Requests enter on the slave stream. tuser selects the kind: clear the table
//   and offset, a code point item, or a line query. tlast marks the last code
//   point item of a text and flushes a pending CR or LF break.
//   Only a query gives a result: the master stream carries the 1-based line
//   number in tdata and the table-full flag in tuser.
// Timing
//   A clear, an unused kind or a code point item is done in S_IDLE; a code point
//   item that records two line starts (a pending break settled plus a break
//   flushed by tlast) also passes S_REC2, one state per write into the table RAM.
//   A query runs one RAM read per binary search step, at most
//   ceil(log2(line count + 1)) steps, the next address formed from the read
//   data in the same cycle. Its result passes from S_SEARCH through S_DONE
//   into the output register, and the next request is taken once S_DONE has
//   handed it on, which waits while the output register still holds an
//   earlier result.
// Reset and stall
//   Reset empties the table (line 1 starts at 0), zeroes the offset and drops
//   any pending break. The table RAM is not cleared; entry 0 reads as zero.
//   A result waits in the output register while the receiver stalls; the next
//   requests are taken meanwhile, and a later query holds its finished result
//   until the output register frees.
module line_start_index_lookup_unit
    import lsil_pkg::*;
#(
    parameter int MAX_LINES   = MAX_LINES_DEF,
    parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // Request stream
    input  logic                i_s_axis_tvalid,
    output logic                o_s_axis_tready,
    // [20:0] code_point, [23:21] byte_length, [24] decode_error,
    // [56:25] query_offset, [63:57] zero
    input  logic [S_DATA_W-1:0] i_s_axis_tdata,
    // [1:0] command
    input  logic [1:0]          i_s_axis_tuser,
    // end_of_text
    input  logic                i_s_axis_tlast,
    // Result stream
    output logic                o_m_axis_tvalid,
    input  logic                i_m_axis_tready,
    // [12:0] line_number, [15:13] zero
    output logic [M_DATA_W-1:0] o_m_axis_tdata,
    // [0] table_full
    output logic                o_m_axis_tuser
);

    localparam int AW    = $clog2(MAX_LINES);
    localparam int CW    = $clog2(MAX_LINES + 1);
    localparam int CMP_W = (OFFSET_BITS > QOFF_W) ? OFFSET_BITS : QOFF_W;
    localparam int EXT_W = CW + LINE_W;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_REC2   = 4'b0010,
        S_SEARCH = 4'b0100,
        S_DONE   = 4'b1000
    } t_state;

    // Request fields
    t_cmd                s_cmd;
    logic [CP_W-1:0]     s_cp;
    logic [LEN_W-1:0]    s_len;
    logic                s_err;
    logic                s_eot;
    logic [QOFF_W-1:0]   s_qoff;

    assign s_cmd  = t_cmd'(i_s_axis_tuser);
    assign s_cp   = i_s_axis_tdata[CP_W-1:0];
    assign s_len  = i_s_axis_tdata[CP_W+LEN_W-1:CP_W];
    assign s_err  = i_s_axis_tdata[CP_W+LEN_W];
    assign s_qoff = i_s_axis_tdata[CP_W+LEN_W+QOFF_W:CP_W+LEN_W+1];
    assign s_eot  = i_s_axis_tlast;

    // State
    t_state                 r_state, n_state;
    logic [CW-1:0]          r_count, n_count;
    logic [OFFSET_BITS-1:0] r_off, n_off;
    t_pend                  r_pend, n_pend;
    logic                   r_ovf, n_ovf;
    // Search
    logic [CW-1:0]          r_lo, n_lo;
    logic [CW-1:0]          r_hi, n_hi;
    logic [AW-1:0]          r_mid, n_mid;
    logic                   r_rd_pend, n_rd_pend;
    logic                   r_rd_zero, n_rd_zero;
    logic [QOFF_W-1:0]      r_qoff, n_qoff;
    // Output register
    logic                   r_out_valid, n_out_valid;
    logic [LINE_W-1:0]      r_out_line, n_out_line;
    logic                   r_out_full, n_out_full;

    // RAM ports
    logic                   ram_we;
    logic [OFFSET_BITS-1:0] ram_wdata;
    logic [OFFSET_BITS-1:0] ram_rdata;
    logic [OFFSET_BITS-1:0] rd_val;

    logic                   accept;
    logic                   full;
    logic                   pair;
    logic                   rec1, rec2;
    logic [OFFSET_BITS:0]   off_sum;
    logic [OFFSET_BITS-1:0] off_adv;
    t_pend                  pend_item;
    logic [CW-1:0]          lo_e, hi_e, mid_e;
    logic                   hit;
    logic                   out_free;
    logic [EXT_W-1:0]       lo_ext;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;
    assign full            = (r_count == CW'(MAX_LINES));
    assign out_free        = !r_out_valid || i_m_axis_tready;

    // Saturating offset advance
    assign off_sum = {1'b0, r_off} + (OFFSET_BITS + 1)'(s_len);
    assign off_adv = off_sum[OFFSET_BITS] ? '1 : off_sum[OFFSET_BITS-1:0];

    // Settle the pending break against this item.
    assign pair = !s_err &&
                  ((r_pend == PEND_CR && s_cp == CH_LF) ||
                   (r_pend == PEND_LF && s_cp == CH_CR));
    assign rec1 = (r_pend != PEND_NONE);

    always_comb begin
        pend_item = PEND_NONE;
        if (!pair && !s_err) begin
            if (s_cp == CH_CR) begin
                pend_item = PEND_CR;
            end else if (s_cp == CH_LF) begin
                pend_item = PEND_LF;
            end
        end
    end

    // A break still pending after the item is flushed by tlast.
    assign rec2 = s_eot && (pend_item != PEND_NONE);

    // Entry 0 is never written and always reads as zero.
    assign rd_val = r_rd_zero ? '0 : ram_rdata;
    assign hit    = (CMP_W'(rd_val) <= CMP_W'(r_qoff));

    // Fold the returned read into the bounds, then form the next probe.
    always_comb begin
        lo_e = r_lo;
        hi_e = r_hi;
        if (r_rd_pend) begin
            if (hit) begin
                lo_e = CW'(r_mid) + CW'(1);
            end else begin
                hi_e = CW'(r_mid);
            end
        end
        mid_e = lo_e + ((hi_e - lo_e) >> 1);
    end

    assign lo_ext = EXT_W'(r_lo);

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_off       = r_off;
        n_pend      = r_pend;
        n_ovf       = r_ovf;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_mid       = r_mid;
        n_rd_pend   = r_rd_pend;
        n_rd_zero   = r_rd_zero;
        n_qoff      = r_qoff;
        n_out_valid = r_out_valid;
        n_out_line  = r_out_line;
        n_out_full  = r_out_full;
        ram_we      = 1'b0;
        ram_wdata   = r_off;

        // Drop the result once the receiver takes it.
        if (r_out_valid && i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    priority case (s_cmd)
                        CMD_CLEAR: begin
                            n_count = CW'(1);
                            n_off   = '0;
                            n_pend  = PEND_NONE;
                            n_ovf   = 1'b0;
                        end
                        CMD_CHAR: begin
                            n_off  = off_adv;
                            n_pend = rec2 ? PEND_NONE : pend_item;
                            if (rec1 || rec2) begin
                                // First start: old offset for a break settled
                                // alone; a completed pair or a flushed break
                                // starts at the new offset.
                                ram_wdata = (rec1 && !pair) ? r_off : off_adv;
                                if (full) begin
                                    n_ovf = 1'b1;
                                end else begin
                                    ram_we  = 1'b1;
                                    n_count = r_count + CW'(1);
                                end
                            end
                            if (rec1 && rec2) begin
                                n_state = S_REC2;
                            end
                        end
                        CMD_QUERY: begin
                            n_lo      = '0;
                            n_hi      = r_count;
                            n_rd_pend = 1'b0;
                            n_qoff    = s_qoff;
                            n_state   = S_SEARCH;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_REC2: begin
                // Record the flushed break at the advanced offset.
                ram_wdata = r_off;
                if (full) begin
                    n_ovf = 1'b1;
                end else begin
                    ram_we  = 1'b1;
                    n_count = r_count + CW'(1);
                end
                n_state = S_IDLE;
            end
            S_SEARCH: begin
                n_lo = lo_e;
                n_hi = hi_e;
                if (lo_e < hi_e) begin
                    n_rd_pend = 1'b1;
                    n_mid     = mid_e[AW-1:0];
                    n_rd_zero = (mid_e == '0);
                end else begin
                    n_rd_pend = 1'b0;
                    n_state   = S_DONE;
                end
            end
            S_DONE: begin
                // Hold the answer until the output register frees.
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_line  = lo_ext[LINE_W-1:0];
                    n_out_full  = r_ovf;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= CW'(1);
            r_off       <= '0;
            r_pend      <= PEND_NONE;
            r_ovf       <= 1'b0;
            r_rd_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_off       <= n_off;
            r_pend      <= n_pend;
            r_ovf       <= n_ovf;
            r_rd_pend   <= n_rd_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo       <= n_lo;
        r_hi       <= n_hi;
        r_mid      <= n_mid;
        r_rd_zero  <= n_rd_zero;
        r_qoff     <= n_qoff;
        r_out_line <= n_out_line;
        r_out_full <= n_out_full;
    end

    lsil_ram #(
        .WIDTH (OFFSET_BITS),
        .DEPTH (MAX_LINES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (ram_wdata),
        .i_raddr (mid_e[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = M_DATA_W'(r_out_line);
    assign o_m_axis_tuser  = r_out_full;

endmodule

>>> hw/rtl/lsil_checker.sv
// Port-level checks for the line start index lookup unit, bound to the top.
// Depends on lsil_pkg and line_start_index_lookup_unit.
module lsil_checker
    import lsil_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_s_axis_tvalid,
    input logic                o_s_axis_tready,
    input logic [1:0]          i_s_axis_tuser,
    input logic                o_m_axis_tvalid,
    input logic                i_m_axis_tready,
    input logic [M_DATA_W-1:0] o_m_axis_tdata,
    input logic                o_m_axis_tuser
);

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("stalled result changed");

    // A query request blocks the next request while its search runs.
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready && i_s_axis_tuser == CMD_QUERY |=>
            !o_s_axis_tready)
        else $error("request taken during search");

    // Only a query produces a result.
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready && i_s_axis_tuser != CMD_QUERY &&
        !o_m_axis_tvalid |=> !o_m_axis_tvalid)
        else $error("result without a query");

endmodule

bind line_start_index_lookup_unit lsil_checker u_lsil_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tuser  (i_s_axis_tuser),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);
